// ===== rtl/tss_pkg.sv =====
`timescale 1ns / 1ps

package tss_pkg;

	localparam int MUL_AW = 53;
	localparam int MUL_BW = 33;
	localparam int MUL_PW = 86;
	localparam int DIV_NW = 62;
	localparam int DIV_DW = 54;
	localparam int SQ_RW  = 66;
	localparam int SQ_QW  = 33;

	localparam logic [39:0] TIME_MAX   = 40'hFF_FFFF_FFFF;
	localparam logic [39:0] MIN_DT     = 40'd7;
	localparam logic [23:0] MIN_SPEED  = 24'd6554;
	localparam logic [25:0] LIM_SAT    = 26'd33554432;
	localparam logic [30:0] LAG_ONE    = 31'd1073741824;
	localparam logic [31:0] CFG_RESET  = 32'd65536;

	localparam logic CFG_ACCEL = 1'b0;
	localparam logic CFG_TAU   = 1'b1;

	localparam logic [1:0] PH_PASS  = 2'd0;
	localparam logic [1:0] PH_START = 2'd1;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_SQX  = 12'b0000_0000_0010,
		ST_SQY  = 12'b0000_0000_0100,
		ST_RTP  = 12'b0000_0000_1000,
		ST_SQZ  = 12'b0000_0001_0000,
		ST_RT3  = 12'b0000_0010_0000,
		ST_DT   = 12'b0000_0100_0000,
		ST_LAG  = 12'b0000_1000_0000,
		ST_MAG  = 12'b0001_0000_0000,
		ST_LIM  = 12'b0010_0000_0000,
		ST_STEP = 12'b0100_0000_0000,
		ST_DONE = 12'b1000_0000_0000
	} state_t;

endpackage

// ===== rtl/tss_mul.sv =====
`timescale 1ns / 1ps

module tss_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tss_pkg::MUL_AW-1:0] a,
	input  logic [tss_pkg::MUL_BW-1:0] b,
	input  logic [tss_pkg::MUL_PW-1:0] acc0,
	output logic                       done,
	output logic [tss_pkg::MUL_PW-1:0] prod
);

	localparam int CW = $clog2(tss_pkg::MUL_BW + 1);

	logic [tss_pkg::MUL_PW-1:0] a_q;
	logic [tss_pkg::MUL_BW-1:0] b_q;
	logic [tss_pkg::MUL_PW-1:0] p_q;
	logic [CW-1:0]              cnt_q;
	logic                       busy_q;
	logic                       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(tss_pkg::MUL_BW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= tss_pkg::MUL_PW'(a);
			b_q <= b;
			p_q <= acc0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				p_q <= p_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

// ===== rtl/tss_div.sv =====
`timescale 1ns / 1ps

module tss_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tss_pkg::DIV_NW-1:0] num,
	input  logic [tss_pkg::DIV_DW-1:0] den,
	output logic                       done,
	output logic [tss_pkg::DIV_NW-1:0] quo
);

	localparam int NW = tss_pkg::DIV_NW;
	localparam int DW = tss_pkg::DIV_DW;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign trial = {r_q, n_q[NW-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= diff[DW-1:0];
				n_q <= {n_q[NW-2:0], 1'b1};
			end else begin
				r_q <= trial[DW-1:0];
				n_q <= {n_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = n_q;

endmodule

// ===== rtl/tss_sqrt.sv =====
`timescale 1ns / 1ps

module tss_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tss_pkg::SQ_RW-1:0] rad,
	output logic                      done,
	output logic [tss_pkg::SQ_QW-1:0] root
);

	localparam int RW = tss_pkg::SQ_RW;
	localparam int QW = tss_pkg::SQ_QW;
	localparam int CW = $clog2(QW + 1);

	logic [RW-1:0] x_q;
	logic [QW:0]   rem_q;
	logic [QW-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [QW+2:0] cur;
	logic [QW+2:0] test;
	logic [QW+2:0] diff;

	assign cur  = {rem_q, x_q[RW-1:RW-2]};
	assign test = {1'b0, root_q, 2'b01};
	assign diff = cur - test;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(QW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= x_q << 2;
			if (cur >= test) begin
				rem_q  <= diff[QW:0];
				root_q <= {root_q[QW-2:0], 1'b1};
			end else begin
				rem_q  <= cur[QW:0];
				root_q <= {root_q[QW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/trajectory_speed_smoother_unit.sv =====
`timescale 1ns / 1ps
// channel   handshake             payload
// in        in_valid / in_stall   pos_x pos_y pos_z speed_in start_speed phase first_point
// out       out_valid / out_stall speed_out rel_time
// cfg       cfg_valid / cfg_ready cfg_index cfg_data
//
// Each point takes five passes of the shift-add multiplier, two passes of
// the root unit and three passes of the divider, run one after another by
// the sequencer. Reset clears control and the previous-point state and
// loads the configuration registers with CFG_RESET. A new point is taken
// while the last result waits on out_stall; the final write stalls only if
// the output register is still full.

module trajectory_speed_smoother_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [23:0] speed_in,
	input  logic signed [23:0] start_speed,
	input  logic        [1:0]  phase,
	input  logic               first_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] speed_out,
	output logic        [39:0] rel_time,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic        [31:0] cfg_data
);

	localparam int AW = tss_pkg::MUL_AW;
	localparam int BW = tss_pkg::MUL_BW;
	localparam int PW = tss_pkg::MUL_PW;
	localparam int NW = tss_pkg::DIV_NW;
	localparam int DW = tss_pkg::DIV_DW;

	tss_pkg::state_t state_q;
	logic            launched_q;

	logic [31:0] accel_q;
	logic [31:0] tau_q;

	logic signed [31:0] x_q, y_q, z_q;
	logic signed [23:0] vin_q, vst_q;
	logic        [1:0]  phase_q;
	logic               first_q;

	logic signed [31:0] last_x_q, last_y_q, last_z_q;
	logic signed [23:0] last_speed_q;
	logic        [39:0] time_sum_q;

	logic [65:0] sum_q;
	logic [32:0] ds_q;
	logic [32:0] d3_q;
	logic [52:0] dt_q;
	logic [30:0] w_q;
	logic [25:0] mag_q;
	logic [25:0] lim_q;
	logic [39:0] step_q;
	logic        step_sat_q;

	logic               out_valid_q;
	logic signed [23:0] speed_out_q;
	logic        [39:0] rel_time_q;

	logic [32:0] dx, dy, dz, adx, ady, adz;
	logic [23:0] av, av_nz, sp;
	logic [24:0] diff, adiff;
	logic [53:0] lag_sum, lag_den;

	logic          mul_start, div_start, sqrt_start;
	logic          mul_done, div_done, sqrt_done;
	logic [AW-1:0] mul_a;
	logic [BW-1:0] mul_b;
	logic [PW-1:0] mul_acc0, mul_prod;
	logic [NW-1:0] div_num, div_quo;
	logic [DW-1:0] div_den;
	logic [32:0]   sqrt_root;
	logic          op_done;
	logic          in_mul, in_div, in_sqrt;

	logic [25:0]        mag_eff;
	logic signed [26:0] v_wide;
	logic signed [23:0] v_next;
	logic [40:0]        t_sum;
	logic [39:0]        t_next;

	assign dx = {x_q[31], x_q} - {last_x_q[31], last_x_q};
	assign dy = {y_q[31], y_q} - {last_y_q[31], last_y_q};
	assign dz = {z_q[31], z_q} - {last_z_q[31], last_z_q};
	assign adx = dx[32] ? (33'd0 - dx) : dx;
	assign ady = dy[32] ? (33'd0 - dy) : dy;
	assign adz = dz[32] ? (33'd0 - dz) : dz;

	assign av    = last_speed_q[23] ? (24'd0 - last_speed_q) : last_speed_q;
	assign av_nz = (av == 24'd0) ? 24'd1 : av;
	assign sp    = (av < tss_pkg::MIN_SPEED) ? tss_pkg::MIN_SPEED : av;

	assign diff  = {vin_q[23], vin_q} - {last_speed_q[23], last_speed_q};
	assign adiff = diff[24] ? (25'd0 - diff) : diff;

	assign lag_sum = {22'd0, tau_q} + {1'b0, dt_q};
	assign lag_den = (lag_sum == 54'd0) ? 54'd1 : lag_sum;

	assign in_mul  = (state_q == tss_pkg::ST_SQX) || (state_q == tss_pkg::ST_SQY) ||
	                 (state_q == tss_pkg::ST_SQZ) || (state_q == tss_pkg::ST_MAG) ||
	                 (state_q == tss_pkg::ST_LIM);
	assign in_div  = (state_q == tss_pkg::ST_DT) || (state_q == tss_pkg::ST_LAG) ||
	                 (state_q == tss_pkg::ST_STEP);
	assign in_sqrt = (state_q == tss_pkg::ST_RTP) || (state_q == tss_pkg::ST_RT3);

	assign mul_start  = in_mul && !launched_q;
	assign div_start  = in_div && !launched_q;
	assign sqrt_start = in_sqrt && !launched_q;
	assign op_done    = mul_done || div_done || sqrt_done;

	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		mul_acc0 = '0;
		div_num  = '0;
		div_den  = DW'(1);
		case (state_q)
			tss_pkg::ST_SQX: begin
				mul_a = AW'(adx);
				mul_b = adx;
			end
			tss_pkg::ST_SQY: begin
				mul_a    = AW'(ady);
				mul_b    = ady;
				mul_acc0 = mul_prod;
			end
			tss_pkg::ST_SQZ: begin
				mul_a    = AW'(adz);
				mul_b    = adz;
				mul_acc0 = PW'(sum_q);
			end
			tss_pkg::ST_MAG: begin
				mul_a    = AW'(w_q);
				mul_b    = BW'(adiff);
				mul_acc0 = PW'(1) << 29;
			end
			tss_pkg::ST_LIM: begin
				mul_a = dt_q;
				mul_b = BW'(accel_q);
			end
			tss_pkg::ST_DT: begin
				div_num = NW'({ds_q, 20'd0});
				div_den = DW'(av_nz);
			end
			tss_pkg::ST_LAG: begin
				div_num = {tau_q, 30'd0};
				div_den = lag_den;
			end
			tss_pkg::ST_STEP: begin
				div_num = NW'({d3_q, 20'd0});
				div_den = DW'(sp);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	tss_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.acc0   (mul_acc0),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	tss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	tss_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (sum_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	assign mag_eff = (mag_q > lim_q) ? lim_q : mag_q;
	assign v_wide  = diff[24] ? (27'(last_speed_q) - $signed({1'b0, mag_eff}))
	                          : (27'(last_speed_q) + $signed({1'b0, mag_eff}));

	always_comb begin
		case (phase_q)
			tss_pkg::PH_PASS:  v_next = vin_q;
			tss_pkg::PH_START: v_next = vst_q;
			default: begin
				if (v_wide > 27'sd8388607) begin
					v_next = 24'sh7FFFFF;
				end else if (v_wide < -27'sd8388608) begin
					v_next = 24'sh800000;
				end else begin
					v_next = v_wide[23:0];
				end
			end
		endcase
	end

	assign t_sum  = {1'b0, time_sum_q} + {1'b0, step_q};
	assign t_next = first_q ? 40'd0 :
	                (step_sat_q || t_sum[40]) ? tss_pkg::TIME_MAX : t_sum[39:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tss_pkg::ST_IDLE;
			launched_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			accel_q      <= tss_pkg::CFG_RESET;
			tau_q        <= tss_pkg::CFG_RESET;
			last_x_q     <= '0;
			last_y_q     <= '0;
			last_z_q     <= '0;
			last_speed_q <= '0;
			time_sum_q   <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					tss_pkg::CFG_ACCEL: accel_q <= cfg_data;
					tss_pkg::CFG_TAU:   tau_q   <= cfg_data;
					default:            accel_q <= accel_q;
				endcase
			end
			if (out_valid_q && !out_stall && state_q != tss_pkg::ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				tss_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= tss_pkg::ST_SQX;
					end
				end
				tss_pkg::ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						last_x_q     <= x_q;
						last_y_q     <= y_q;
						last_z_q     <= z_q;
						last_speed_q <= v_next;
						time_sum_q   <= t_next;
						state_q      <= tss_pkg::ST_IDLE;
					end
				end
				default: begin
					if (!launched_q) begin
						launched_q <= 1'b1;
					end else if (op_done) begin
						launched_q <= 1'b0;
						case (state_q)
							tss_pkg::ST_SQX:  state_q <= tss_pkg::ST_SQY;
							tss_pkg::ST_SQY:  state_q <= tss_pkg::ST_RTP;
							tss_pkg::ST_RTP:  state_q <= tss_pkg::ST_SQZ;
							tss_pkg::ST_SQZ:  state_q <= tss_pkg::ST_RT3;
							tss_pkg::ST_RT3:  state_q <= tss_pkg::ST_DT;
							tss_pkg::ST_DT:   state_q <= tss_pkg::ST_LAG;
							tss_pkg::ST_LAG:  state_q <= tss_pkg::ST_MAG;
							tss_pkg::ST_MAG:  state_q <= tss_pkg::ST_LIM;
							tss_pkg::ST_LIM:  state_q <= tss_pkg::ST_STEP;
							tss_pkg::ST_STEP: state_q <= tss_pkg::ST_DONE;
							default:          state_q <= tss_pkg::ST_IDLE;
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tss_pkg::ST_IDLE && in_valid) begin
			x_q     <= pos_x;
			y_q     <= pos_y;
			z_q     <= pos_z;
			vin_q   <= speed_in;
			vst_q   <= start_speed;
			phase_q <= phase;
			first_q <= first_point;
		end
		if (launched_q && op_done) begin
			case (state_q)
				tss_pkg::ST_SQY: sum_q <= mul_prod[65:0];
				tss_pkg::ST_SQZ: sum_q <= mul_prod[65:0];
				tss_pkg::ST_RTP: ds_q  <= sqrt_root;
				tss_pkg::ST_RT3: d3_q  <= sqrt_root;
				tss_pkg::ST_DT:  dt_q  <= div_quo[52:0];
				tss_pkg::ST_LAG: begin
					w_q <= (div_quo > NW'(tss_pkg::LAG_ONE)) ? 31'd0
					       : (tss_pkg::LAG_ONE - div_quo[30:0]);
				end
				tss_pkg::ST_MAG: mag_q <= mul_prod[55:30];
				tss_pkg::ST_LIM: begin
					lim_q <= ((|mul_prod[85:42]) || (mul_prod[41:16] > tss_pkg::LIM_SAT))
					         ? tss_pkg::LIM_SAT : mul_prod[41:16];
				end
				tss_pkg::ST_STEP: begin
					step_sat_q <= (|div_quo[61:40]) || (div_quo[39:0] == tss_pkg::TIME_MAX);
					step_q     <= (div_quo[39:0] < tss_pkg::MIN_DT) ? tss_pkg::MIN_DT
					              : div_quo[39:0];
				end
				default: begin
					step_q <= step_q;
				end
			endcase
		end
		if (state_q == tss_pkg::ST_DONE && (!out_valid_q || !out_stall)) begin
			speed_out_q <= v_next;
			rel_time_q  <= t_next;
		end
	end

	assign in_stall  = (state_q != tss_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign speed_out = speed_out_q;
	assign rel_time  = rel_time_q;
	assign cfg_ready = 1'b1;

endmodule

// ===== rtl/tss_chk.sv =====
`timescale 1ns / 1ps

module tss_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [23:0] speed_out,
	input logic [39:0] rel_time
);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input side open right after a transfer");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a point in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(speed_out) && $stable(rel_time))
		else $error("stalled result changed");

endmodule

bind trajectory_speed_smoother_unit tss_chk u_tss_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.speed_out (speed_out),
	.rel_time  (rel_time)
);

// ===== sim/tss_checker.sv =====
`timescale 1ns / 1ps

module tss_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [23:0] speed_in,
	input  logic signed [23:0] start_speed,
	input  logic        [1:0]  phase,
	input  logic               first_point,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [23:0] speed_out,
	input  logic        [39:0] rel_time,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_index,
	input  logic        [31:0] cfg_data,
	input  logic               done,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic signed [23:0] speed;
		logic [39:0] t;
	} point_result_t;

	point_result_t result_q[$];
	logic [31:0] accel_reg, tau_reg;
	logic signed [63:0] prev_x, prev_y, prev_z, prev_speed;
	logic [63:0] time_acc;
	logic end_seen;

	assign pending = result_q.size();

	function automatic logic [63:0] isqrt(input logic [127:0] v);
		logic [63:0] r;
		logic [63:0] c;
		r = 0;
		for (int b = 34; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (128'(c) * 128'(c) <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [63:0] planar_len(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] c);
		return isqrt(128'(a) * a + 128'(b) * b + 128'(c) * c);
	endfunction

	function automatic point_result_t smooth_point(input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z,
			input logic signed [23:0] vin, input logic signed [23:0] vst,
			input logic [1:0] ph, input logic fp);
		logic signed [63:0] dx, dy, dz, v, v0, diff;
		logic [63:0] ds, av, dt, den, aq, w, mag, lim, d, sp, stp;
		logic [127:0] prod;
		point_result_t r;
		dx = 64'(x) - prev_x;
		dy = 64'(y) - prev_y;
		dz = 64'(z) - prev_z;
		if (ph == tss_pkg::PH_PASS) begin
			v = 64'(vin);
		end else if (ph == tss_pkg::PH_START) begin
			v = 64'(vst);
		end else begin
			v0 = prev_speed;
			ds = planar_len(mag64(dx), mag64(dy), 0);
			av = mag64(v0);
			if (av == 0) av = 1;
			dt = (ds << 20) / av;
			den = 64'(tau_reg) + dt;
			if (den == 0) den = 1;
			aq = (64'(tau_reg) << 30) / den;
			if (aq > (64'd1 << 30)) aq = 64'd1 << 30;
			w = (64'd1 << 30) - aq;
			diff = 64'(vin) - v0;
			mag = (mag64(diff) * w + (64'd1 << 29)) >> 30;
			prod = 128'(accel_reg) * 128'(dt);
			lim = (prod[127:64] != 0) ? 64'(tss_pkg::LIM_SAT) : prod[63:0] >> 16;
			if (lim > 64'(tss_pkg::LIM_SAT)) lim = 64'(tss_pkg::LIM_SAT);
			if (mag > lim) mag = lim;
			v = diff < 0 ? v0 - 64'(mag) : v0 + 64'(mag);
			if (v > 64'sd8388607) v = 64'sd8388607;
			if (v < -64'sd8388608) v = -64'sd8388608;
		end
		if (fp) begin
			time_acc = 0;
		end else begin
			d = planar_len(mag64(dx), mag64(dy), mag64(dz));
			sp = mag64(prev_speed);
			if (sp < 64'(tss_pkg::MIN_SPEED)) sp = 64'(tss_pkg::MIN_SPEED);
			stp = (d << 20) / sp;
			if (stp < 64'(tss_pkg::MIN_DT)) stp = 64'(tss_pkg::MIN_DT);
			if (stp >= 64'(tss_pkg::TIME_MAX) || time_acc > 64'(tss_pkg::TIME_MAX) - stp)
				time_acc = 64'(tss_pkg::TIME_MAX);
			else
				time_acc = time_acc + stp;
		end
		prev_x = 64'(x);
		prev_y = 64'(y);
		prev_z = 64'(z);
		prev_speed = v;
		r.speed = v[23:0];
		r.t = time_acc[39:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		point_result_t e;
		int nf;
		if (!arst_n) begin
			accel_reg <= tss_pkg::CFG_RESET;
			tau_reg <= tss_pkg::CFG_RESET;
			prev_x = 0;
			prev_y = 0;
			prev_z = 0;
			prev_speed = 0;
			time_acc = 0;
			fail_count <= 0;
			end_seen <= 1'b0;
			result_q.delete();
		end else begin
			nf = fail_count;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == tss_pkg::CFG_ACCEL)
					accel_reg <= cfg_data;
				else
					tau_reg <= cfg_data;
			end
			if (in_valid && !in_stall)
				result_q.insert(result_q.size(), smooth_point(pos_x, pos_y, pos_z,
					speed_in, start_speed, phase, first_point));
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					if (nf < 10)
						$display("unexpected transfer: speed %0d time %0d",
							speed_out, rel_time);
					nf = nf + 1;
				end else begin
					e = result_q.pop_front();
					if (e.speed !== speed_out || e.t !== rel_time) begin
						if (nf < 10)
							$display("mismatch: speed exp %0d got %0d, time exp %0d got %0d",
								e.speed, speed_out, e.t, rel_time);
						nf = nf + 1;
					end
				end
			end
			if (done && !end_seen) begin
				end_seen <= 1'b1;
				if (result_q.size() != 0) begin
					$display("%0d results never arrived", result_q.size());
					nf = nf + 1;
				end
			end
			fail_count <= nf;
		end
	end
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [23:0] speed_in, start_speed, speed_out;
	logic [1:0] phase;
	logic first_point;
	logic [39:0] rel_time;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [31:0] cfg_data;
	logic done, stall_on;
	int fail_count, pending;

	trajectory_speed_smoother_unit DUT (.*);

	tss_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000000;
		$display("trajectory_speed_smoother_unit verification failed");
		$finish;
	end

	// receiver stall: alternate free and stalling stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
			stall_on <= 0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				stall_on <= !stall_on;
			out_stall <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b0;
		end
	end

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z, input logic signed [23:0] v,
			input logic signed [23:0] vs, input logic [1:0] ph, input logic fp);
		in_valid <= 1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		speed_in <= v;
		start_speed <= vs;
		phase <= ph;
		first_point <= fp;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drop_valid();
		in_valid <= 0;
	endtask

	task automatic drain();
		drop_valid();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic random_traj(input int n, input int step_bits);
		logic signed [31:0] x, y, z;
		int burst;
		x = $urandom;
		y = $urandom;
		z = $urandom;
		x = x >>> 4;
		y = y >>> 4;
		z = z >>> 4;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				drop_valid();
				repeat ($urandom_range(1, 600)) @(posedge clk);
				burst = $urandom_range(1, 12);
			end
			burst--;
			if ($urandom_range(0, 9) == 0) begin
				send_point($urandom, $urandom, $urandom, 24'($urandom), 24'($urandom),
					2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
			end else begin
				x = x + $signed($urandom_range(0, (1 << step_bits) - 1)) - (1 << (step_bits - 1));
				y = y + $signed($urandom_range(0, (1 << step_bits) - 1)) - (1 << (step_bits - 1));
				z = z + $signed($urandom_range(0, (1 << 10) - 1)) - 512;
				send_point(x, y, z, 24'($signed(24'($urandom_range(0, 1 << 22))) - (1 << 21)),
					24'($urandom),
					(i == 0) ? 2'd1 : ($urandom_range(0, 15) == 0 ? 2'd0 : 2'd2),
					i == 0);
			end
		end
	endtask

	initial begin
		arst_n = 0;
		done = 0;
		in_valid = 0;
		pos_x = 0;
		pos_y = 0;
		pos_z = 0;
		speed_in = 0;
		start_speed = 0;
		phase = 0;
		first_point = 0;
		cfg_valid = 0;
		cfg_index = tss_pkg::CFG_ACCEL;
		cfg_data = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset state, extremes, all phases
		send_point(32'sd4096, 32'sd0, 32'sd0, 24'sd65536, 24'sd0, 2'd2, 1'b0);
		send_point(32'sd8192, 32'sd4096, 32'sd100, 24'sd200000, 24'sd0, 2'd2, 1'b1);
		send_point(32'sd8192, 32'sd4096, 32'sd100, 24'sd0, 24'sd0, 2'd2, 1'b0);
		send_point(32'sd8192, 32'sd4096, 32'sd100, 24'sd100, 24'sd0, 2'd2, 1'b0);
		send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'h7FFFFF, 24'h800000,
			2'd0, 1'b0);
		send_point(32'h80000000, 32'h80000000, 32'h80000000, 24'h800000, 24'h7FFFFF,
			2'd1, 1'b0);
		send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'h7FFFFF, 24'h000000,
			2'd2, 1'b0);
		send_point(32'h80000000, 32'h80000000, 32'h80000000, 24'h800000, 24'h7FFFFF,
			2'd3, 1'b0);
		send_point(32'sd0, 32'sd0, 32'sd0, 24'h7FFFFF, 24'h800000, 2'd1, 1'b1);
		send_point(32'sd0, 32'sd0, 32'sd0, 24'h800000, 24'h0, 2'd2, 1'b0);
		send_point(32'h7FFFFFFF, 32'h80000000, 32'sd0, 24'h0, 24'h0, 2'd0, 1'b0);
		drain();
		write_reg(tss_pkg::CFG_TAU, 32'd0);
		write_reg(tss_pkg::CFG_ACCEL, 32'hFFFFFFFF);
		send_point(32'sd0, 32'sd0, 32'sd0, 24'sd1000, 24'sd0, 2'd1, 1'b1);
		send_point(32'sd0, 32'sd0, 32'sd0, 24'sd5000, 24'sd0, 2'd2, 1'b0);
		send_point(32'sd40960, 32'sd0, 32'sd0, 24'h7FFFFF, 24'sd0, 2'd2, 1'b0);
		send_point(32'sd81920, 32'sd0, 32'sd0, 24'h800000, 24'sd0, 2'd2, 1'b0);
		drain();
		write_reg(tss_pkg::CFG_ACCEL, 32'd0);
		write_reg(tss_pkg::CFG_TAU, 32'hFFFFFFFF);
		send_point(32'sd0, 32'sd0, 32'sd0, 24'sd1000, 24'sd70000, 2'd1, 1'b1);
		send_point(32'sd40960, 32'sd4096, 32'sd0, 24'sd500000, 24'sd0, 2'd2, 1'b0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(tss_pkg::CFG_ACCEL, tss_pkg::CFG_RESET);
					write_reg(tss_pkg::CFG_TAU, tss_pkg::CFG_RESET); end
				1: begin write_reg(tss_pkg::CFG_ACCEL, $urandom);
					write_reg(tss_pkg::CFG_TAU, $urandom); end
				2: begin write_reg(tss_pkg::CFG_ACCEL, 32'd0);
					write_reg(tss_pkg::CFG_TAU, 32'd0); end
				3: begin write_reg(tss_pkg::CFG_ACCEL, 32'hFFFFFFFF);
					write_reg(tss_pkg::CFG_TAU, 32'hFFFFFFFF); end
				4: begin write_reg(tss_pkg::CFG_ACCEL, $urandom_range(0, 1 << 20));
					write_reg(tss_pkg::CFG_TAU, $urandom_range(0, 1 << 19)); end
				default: begin write_reg(tss_pkg::CFG_ACCEL, $urandom_range(1 << 15, 1 << 18));
					write_reg(tss_pkg::CFG_TAU, $urandom_range(1 << 14, 1 << 17)); end
			endcase
			for (int t = 0; t < 6; t++)
				random_traj($urandom_range(20, 40), (t % 2) ? 22 : 14);
			drain();
		end

		done <= 1;
		@(posedge clk);
		@(posedge clk);
		if (fail_count == 0)
			$display("trajectory_speed_smoother_unit verification clean");
		else
			$display("trajectory_speed_smoother_unit verification failed");
		$finish;
	end
endmodule

// ===== trajectory_speed_smoother_unit.f =====
rtl/tss_pkg.sv
rtl/tss_mul.sv
rtl/tss_div.sv
rtl/tss_sqrt.sv
rtl/trajectory_speed_smoother_unit.sv
rtl/tss_chk.sv
sim/tss_checker.sv
sim/tb.sv
